[hw/rtl/vertex_transform_project_top_defines.svh]
// ----------------------------------------------------------------------------
// Vertex transform assertion macros
// Shared property forms for the checker of the vertex transform block.
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_PROJECT_TOP_DEFINES_SVH
`define VERTEX_TRANSFORM_PROJECT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VTP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VTP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/vtp_pkg.sv]
// ----------------------------------------------------------------------------
// Vertex transform package
// Shared constants, types and the saturation helper.
// ----------------------------------------------------------------------------
package vtp_pkg;

    localparam int SCREEN_WIDTH_DEF  = 640;
    localparam int SCREEN_HEIGHT_DEF = 480;

    localparam int Q_W       = 32;
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int WIDE_W    = 50;

    localparam int MAC_LAT   = 2;
    localparam int DIV_BITS  = 48;
    localparam int DIV_STEP  = 4;
    localparam int DIV_NS    = DIV_BITS / DIV_STEP;
    localparam int DIV_LAT   = DIV_NS + 2;

    typedef logic [15:0][Q_W-1:0] coef_t;
    typedef logic [3:0][Q_W-1:0]  vec4_t;

    // Returns {clamped, value} for a wide signed value squeezed into Q16.16.
    function automatic logic [Q_W:0] clamp_q(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] qmax;
        logic signed [WIDE_W-1:0] qmin;
        qmax = WIDE_W'(64'sh7FFF_FFFF);
        qmin = -WIDE_W'(64'sh8000_0000);
        if (v > qmax) begin
            return {1'b1, 1'b0, {(Q_W-1){1'b1}}};
        end else if (v < qmin) begin
            return {1'b1, 1'b1, {(Q_W-1){1'b0}}};
        end
        return {1'b0, v[Q_W-1:0]};
    endfunction

endpackage

[hw/rtl/vtp_mac.sv]
// ----------------------------------------------------------------------------
// Vertex transform matrix stage
// Sixteen registered products, then per-row sum, floor scaling and clamp.
// ----------------------------------------------------------------------------
module vtp_mac (
    input  logic            aclk,
    input  logic            en,
    input  vtp_pkg::coef_t  coef,
    input  vtp_pkg::vec4_t  vin,
    output vtp_pkg::vec4_t  tout,
    output logic [3:0]      tsat
);
    import vtp_pkg::*;

    logic signed [2*Q_W-1:0] prod_reg [16];
    vec4_t                   t_reg;
    logic [3:0]              sat_reg;
    vec4_t                   t_next;
    logic [3:0]              sat_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 16; i++) begin
                prod_reg[i] <= $signed(coef[i]) * $signed(vin[i % 4]);
            end
            t_reg   <= t_next;
            sat_reg <= sat_next;
        end
    end

    always_comb begin
        logic signed [2*Q_W+1:0] sum;
        logic [Q_W:0]            c;
        for (int r = 0; r < 4; r++) begin
            sum = (2*Q_W+2)'(prod_reg[4*r]) + (2*Q_W+2)'(prod_reg[4*r+1])
                + (2*Q_W+2)'(prod_reg[4*r+2]) + (2*Q_W+2)'(prod_reg[4*r+3]);
            c = clamp_q(WIDE_W'(sum >>> 16));
            t_next[r]   = c[Q_W-1:0];
            sat_next[r] = c[Q_W];
        end
    end

    assign tout = t_reg;
    assign tsat = sat_reg;

endmodule

[hw/rtl/vtp_div.sv]
// ----------------------------------------------------------------------------
// Vertex transform divider
// Pipelined restoring divider for (num * 65536) / den, truncated and clamped.
// ----------------------------------------------------------------------------
module vtp_div (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [vtp_pkg::Q_W-1:0] num,
    input  logic [vtp_pkg::Q_W-1:0] den,
    output logic [vtp_pkg::Q_W-1:0] quo,
    output logic                  sat
);
    import vtp_pkg::*;

    logic [DIV_BITS-1:0] work_reg [DIV_NS+1];
    logic [Q_W-1:0]      rem_reg  [DIV_NS+1];
    logic [Q_W-1:0]      den_reg  [DIV_NS+1];
    logic                neg_reg  [DIV_NS+1];
    logic [Q_W-1:0]      quo_reg;
    logic                sat_reg;
    logic [Q_W:0]        fin_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            work_reg[0] <= {(num[Q_W-1] ? Q_W'(-num) : num), 16'b0};
            rem_reg[0]  <= '0;
            den_reg[0]  <= den[Q_W-1] ? Q_W'(-den) : den;
            neg_reg[0]  <= num[Q_W-1] ^ den[Q_W-1];
        end
    end

    for (genvar k = 1; k <= DIV_NS; k++) begin : g_stage
        logic [DIV_BITS-1:0] w_next;
        logic [Q_W-1:0]      r_next;

        always_comb begin
            logic [Q_W:0]        r;
            logic [DIV_BITS-1:0] w;
            r = {1'b0, rem_reg[k-1]};
            w = work_reg[k-1];
            for (int j = 0; j < DIV_STEP; j++) begin
                r = {r[Q_W-1:0], w[DIV_BITS-1]};
                w = {w[DIV_BITS-2:0], 1'b0};
                if (r >= {1'b0, den_reg[k-1]}) begin
                    r    = r - {1'b0, den_reg[k-1]};
                    w[0] = 1'b1;
                end
            end
            w_next = w;
            r_next = r[Q_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                work_reg[k] <= w_next;
                rem_reg[k]  <= r_next;
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
            end
        end
    end

    always_comb begin
        logic signed [DIV_BITS:0] q;
        q = {1'b0, work_reg[DIV_NS]};
        if (neg_reg[DIV_NS]) begin
            q = -q;
        end
        fin_next = clamp_q(WIDE_W'(q));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= fin_next[Q_W-1:0];
            sat_reg <= fin_next[Q_W];
        end
    end

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule

[hw/rtl/vertex_transform_project_top.sv]
// ----------------------------------------------------------------------------
// Vertex transform and projection, top level
// The block takes one Q16.16 vertex per cycle while the output is not stalled,
// multiplies it by the configured 4x4 matrix, divides x, y and z by the
// transformed w (passing them through undivided when w is zero), and maps the
// result to screen space. It is a stalling pipeline of 17 register stages: two
// for the matrix products and row sums, 14 for the 48-bit restoring divider
// whose inner stages retire four quotient bits each, and one for the screen
// mapping. The whole pipeline holds while the output word waits. Matrix writes
// are taken in any cycle and should only be made while the pipeline is empty.
// ----------------------------------------------------------------------------
module vertex_transform_project_top #(
    parameter int SCREEN_WIDTH  = vtp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = vtp_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vtp_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [127:0]                  s_tdata,   // vx, vy, vz, vw
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [95:0]                   m_tdata,   // screen_x, screen_y, depth
    output logic [1:0]                    m_tuser    // w_was_zero, saturated
);
    import vtp_pkg::*;

    localparam int LAT = MAC_LAT + DIV_LAT + 1;
    localparam logic signed [WIDE_W-1:0] HALF_W = WIDE_W'(SCREEN_WIDTH) <<< 15;
    localparam logic signed [WIDE_W-1:0] HALF_H = WIDE_W'(SCREEN_HEIGHT) <<< 15;

    logic [63:0]    cfg_reg [REG_COUNT];
    logic [LAT-1:0] vld_reg;
    logic           en;
    coef_t          coef;
    vec4_t          tvec;
    logic [3:0]     tsat;
    logic [Q_W-1:0] quo [3];
    logic [2:0]     qsat;
    logic [Q_W-1:0] tx_reg [DIV_LAT];
    logic [Q_W-1:0] ty_reg [DIV_LAT];
    logic [Q_W-1:0] tz_reg [DIV_LAT];
    logic           wz_reg [DIV_LAT];
    logic           ts_reg [DIV_LAT];
    logic [95:0]    out_data_reg;
    logic [1:0]     out_user_reg;
    logic [95:0]    out_data_next;
    logic [1:0]     out_user_next;

    assign en        = !vld_reg[LAT-1] || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[0] <= 64'h0000_0000_0001_0000;
            cfg_reg[1] <= '0;
            cfg_reg[2] <= 64'h0001_0000_0000_0000;
            cfg_reg[3] <= '0;
            cfg_reg[4] <= '0;
            cfg_reg[5] <= 64'h0000_0000_0001_0000;
            cfg_reg[6] <= '0;
            cfg_reg[7] <= 64'h0001_0000_0000_0000;
        end else if (cfg_valid) begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                coef[4*r+c] = cfg_reg[2*r + c/2][32*(c%2) +: 32];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    vtp_mac u_mac (
        .aclk (aclk),
        .en   (en),
        .coef (coef),
        .vin  (s_tdata),
        .tout (tvec),
        .tsat (tsat)
    );

    for (genvar i = 0; i < 3; i++) begin : g_div
        vtp_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (tvec[i]),
            .den  (tvec[3]),
            .quo  (quo[i]),
            .sat  (qsat[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tx_reg[0] <= tvec[0];
            ty_reg[0] <= tvec[1];
            tz_reg[0] <= tvec[2];
            wz_reg[0] <= (tvec[3] == '0);
            ts_reg[0] <= |tsat;
            for (int k = 1; k < DIV_LAT; k++) begin
                tx_reg[k] <= tx_reg[k-1];
                ty_reg[k] <= ty_reg[k-1];
                tz_reg[k] <= tz_reg[k-1];
                wz_reg[k] <= wz_reg[k-1];
                ts_reg[k] <= ts_reg[k-1];
            end
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    always_comb begin
        logic           wz;
        logic [Q_W-1:0] x;
        logic [Q_W-1:0] y;
        logic [Q_W-1:0] z;
        logic [Q_W:0]   sx;
        logic [Q_W:0]   sy;
        wz = wz_reg[DIV_LAT-1];
        x  = wz ? tx_reg[DIV_LAT-1] : quo[0];
        y  = wz ? ty_reg[DIV_LAT-1] : quo[1];
        z  = wz ? tz_reg[DIV_LAT-1] : quo[2];
        sx = clamp_q(HALF_W - WIDE_W'($signed(x)));
        sy = clamp_q(HALF_H - WIDE_W'($signed(y)));
        out_data_next = {z, sy[Q_W-1:0], sx[Q_W-1:0]};
        out_user_next = {ts_reg[DIV_LAT-1] | (!wz && (|qsat)) | sx[Q_W] | sy[Q_W], wz};
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

[hw/rtl/vtp_checker.sv]
// ----------------------------------------------------------------------------
// Vertex transform port checker
// Watches the top-level ports for flow-control and stall behavior.
// ----------------------------------------------------------------------------
`include "vertex_transform_project_top_defines.svh"

module vtp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata,
    input logic [1:0]   m_tuser
);
    `VTP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")
    `VTP_ASSERT_NOW(a_ready_free, aclk, aresetn, !m_tvalid || m_tready, s_tready, "input stalled with free output")
    `VTP_ASSERT_NOW(a_ready_stall, aclk, aresetn, !s_tready, m_tvalid && !m_tready, "input stalled without output stall")

endmodule

bind vertex_transform_project_top vtp_checker u_vtp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
